[design/rigid_body_integration_step_core_macros.svh]
// Assertion macros for the rigid body integration step core.
// Included by the top level; no other dependencies.
`ifndef RIGID_BODY_INTEGRATION_STEP_CORE_MACROS_SVH
`define RIGID_BODY_INTEGRATION_STEP_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RBIS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define RBIS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/rbis_pkg.sv]
// Shared types and constants for the rigid body integration step core.
// No dependencies.
package rbis_pkg;

   // fixed-point format of all Q values except the time step
   localparam int unsigned RBIS_FRAC_BITS = 16;

   // angular limits, negative disables the clamp
   localparam logic signed [31:0] RBIS_MAX_ANG_ACCEL = -32'sd65536;
   localparam logic signed [31:0] RBIS_MAX_ANG_VEL   = -32'sd65536;

   // 0.5 * 1.293 in Q0.16
   localparam logic [15:0] RBIS_DRAG_HALF_RHO = 16'd42369;

   // register indexes
   localparam logic [2:0] REG_MODE_FLAGS   = 3'd0;
   localparam logic [2:0] REG_INVERSE_MASS = 3'd1;
   localparam logic [2:0] REG_GRAVITY_X    = 3'd2;
   localparam logic [2:0] REG_GRAVITY_Y    = 3'd3;
   localparam logic [2:0] REG_GRAVITY_Z    = 3'd4;
   localparam logic [2:0] REG_DRAG_COEFF   = 3'd5;
   localparam logic [2:0] REG_MAX_LIN_ACC  = 3'd6;
   localparam logic [2:0] REG_MAX_LIN_VEL  = 3'd7;

   // register reset values
   localparam logic [1:0]         RST_MODE_FLAGS   = 2'd2;
   localparam logic [30:0]        RST_INVERSE_MASS = 31'd65536;
   localparam logic signed [31:0] RST_GRAVITY_Y    = -32'sd642253;
   localparam logic signed [31:0] RST_LIMIT        = -32'sd65536;

   typedef struct packed {
      logic        start;
      logic [63:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

endpackage

[design/rigid_body_integration_step_core.sv]
// Rigid body integration step: one body, Q16.16, one result beat per input beat.
// Depends on rbis_pkg, rbis_mul, rbis_sqrt, rbis_div and the macros header.
//
// Usage:
//  - Input channel (req_*): valid/ready; one beat is one tick (time step,
//    force, angular acceleration). req_ready is high only while the sequencer
//    is idle; a beat is accepted when req_valid and req_ready are both high.
//  - Result channel (rsp_*): valid/ready; one beat carries the new position,
//    rotation, linear and angular velocity. The result sits in an output
//    register, so the next tick is taken while a result still waits.
//  - Config (APB, pready tied high): eight 32-bit registers at 4*index.
// Sequence: a static body goes straight from idle to the result step. Otherwise,
//  with all clamps disabled: velocity magnitude (bit-serial square root), drag
//  and acceleration, then integration. Each enabled clamp adds a magnitude step,
//  and three divisions through the bit-serial divider when it actually scales;
//  only the two linear clamps can be enabled.
//  A new tick is taken only once the previous one has reached the result step:
//  the multiplier, root and divider units are shared by every step.
// Reset: synchronous; state vectors go to zero, registers to their defaults.
// Stall: a waiting result holds the sequencer in its final step until the
//  output register frees up; no beat is lost.
module rigid_body_integration_step_core (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_time_step,
   input  logic signed [31:0] req_force_x,
   input  logic signed [31:0] req_force_y,
   input  logic signed [31:0] req_force_z,
   input  logic signed [31:0] req_ang_accel_x,
   input  logic signed [31:0] req_ang_accel_y,
   input  logic signed [31:0] req_ang_accel_z,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_pos_x,
   output logic signed [31:0] rsp_out_pos_y,
   output logic signed [31:0] rsp_out_pos_z,
   output logic signed [31:0] rsp_out_pitch,
   output logic signed [31:0] rsp_out_yaw,
   output logic signed [31:0] rsp_out_roll,
   output logic signed [31:0] rsp_out_vel_x,
   output logic signed [31:0] rsp_out_vel_y,
   output logic signed [31:0] rsp_out_vel_z,
   output logic signed [31:0] rsp_out_angvel_x,
   output logic signed [31:0] rsp_out_angvel_y,
   output logic signed [31:0] rsp_out_angvel_z,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import rbis_pkg::*;

   `include "rigid_body_integration_step_core_macros.svh"

   // sequencer codes
   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_MAG_MUL  = 5'd1;   // square one element
   localparam logic [4:0] ST_MAG_ACC  = 5'd2;   // accumulate, launch root
   localparam logic [4:0] ST_MAG_SQRT = 5'd3;
   localparam logic [4:0] ST_D_M1     = 5'd4;   // |v| * drag
   localparam logic [4:0] ST_D_U1     = 5'd5;
   localparam logic [4:0] ST_D_M2     = 5'd6;   // * 0.6465
   localparam logic [4:0] ST_D_U2     = 5'd7;
   localparam logic [4:0] ST_D_M3     = 5'd8;   // * inverse mass
   localparam logic [4:0] ST_D_U3     = 5'd9;
   localparam logic [4:0] ST_A_M1     = 5'd10;  // force * inverse mass
   localparam logic [4:0] ST_A_U1     = 5'd11;
   localparam logic [4:0] ST_A_M2     = 5'd12;  // v * drag scalar
   localparam logic [4:0] ST_A_U2     = 5'd13;
   localparam logic [4:0] ST_C_SEL    = 5'd14;  // pick next vector to clamp
   localparam logic [4:0] ST_C_M      = 5'd15;  // element * limit
   localparam logic [4:0] ST_C_DIV    = 5'd16;
   localparam logic [4:0] ST_C_W      = 5'd17;
   localparam logic [4:0] ST_I_M1     = 5'd18;  // a * dt
   localparam logic [4:0] ST_I_U1     = 5'd19;
   localparam logic [4:0] ST_I_M2     = 5'd20;  // adt * dt
   localparam logic [4:0] ST_I_U2     = 5'd21;
   localparam logic [4:0] ST_I_M3     = 5'd22;  // v * dt
   localparam logic [4:0] ST_I_U3     = 5'd23;  // write back p and v
   localparam logic [4:0] ST_FIN      = 5'd24;

   // vector slots: acceleration, velocity, angular accel, angular velocity
   localparam logic [1:0] VS_ACC = 2'd0;
   localparam logic [1:0] VS_VEL = 2'd1;
   localparam logic [1:0] VS_ANG = 2'd2;
   localparam logic [1:0] VS_W   = 2'd3;

   localparam logic signed [65:0] S32_HI = 66'sd2147483647;
   localparam logic signed [65:0] S32_LO = -66'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > S32_HI) begin
         r = 32'sh7FFFFFFF;
      end else if (v < S32_LO) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // ---------------- configuration registers ----------------
   logic [1:0]         mode_ff, mode_in;
   logic [30:0]        invm_ff, invm_in;
   logic signed [31:0] grav_ff [3];
   logic signed [31:0] grav_in [3];
   logic [30:0]        drag_ff, drag_in;
   logic signed [31:0] max_acc_ff, max_acc_in;
   logic signed [31:0] max_vel_ff, max_vel_in;
   logic               csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      mode_in    = mode_ff;
      invm_in    = invm_ff;
      grav_in    = grav_ff;
      drag_in    = drag_ff;
      max_acc_in = max_acc_ff;
      max_vel_in = max_vel_ff;
      if (csr_wr) begin
         unique case (paddr[4:2])
            REG_MODE_FLAGS:   mode_in    = pwdata[1:0];
            REG_INVERSE_MASS: invm_in    = pwdata[30:0];
            REG_GRAVITY_X:    grav_in[0] = pwdata;
            REG_GRAVITY_Y:    grav_in[1] = pwdata;
            REG_GRAVITY_Z:    grav_in[2] = pwdata;
            REG_DRAG_COEFF:   drag_in    = pwdata[30:0];
            REG_MAX_LIN_ACC:  max_acc_in = pwdata;
            REG_MAX_LIN_VEL:  max_vel_in = pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_MODE_FLAGS:   prdata = {30'b0, mode_ff};
         REG_INVERSE_MASS: prdata = {1'b0, invm_ff};
         REG_GRAVITY_X:    prdata = grav_ff[0];
         REG_GRAVITY_Y:    prdata = grav_ff[1];
         REG_GRAVITY_Z:    prdata = grav_ff[2];
         REG_DRAG_COEFF:   prdata = {1'b0, drag_ff};
         REG_MAX_LIN_ACC:  prdata = max_acc_ff;
         REG_MAX_LIN_VEL:  prdata = max_vel_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= RST_MODE_FLAGS;
         invm_ff    <= RST_INVERSE_MASS;
         grav_ff[0] <= '0;
         grav_ff[1] <= RST_GRAVITY_Y;
         grav_ff[2] <= '0;
         drag_ff    <= '0;
         max_acc_ff <= RST_LIMIT;
         max_vel_ff <= RST_LIMIT;
      end else begin
         mode_ff    <= mode_in;
         invm_ff    <= invm_in;
         grav_ff    <= grav_in;
         drag_ff    <= drag_in;
         max_acc_ff <= max_acc_in;
         max_vel_ff <= max_vel_in;
      end
   end

   // ---------------- sequencer and datapath registers ----------------
   logic [4:0]         state_ff, state_in;
   logic [1:0]         ax_ff, ax_in;          // axis within a vector
   logic [1:0]         vs_ff, vs_in;          // vector slot being clamped
   logic               grp_ff, grp_in;        // integration: 0 linear, 1 angular
   logic               drag_ph_ff, drag_ph_in;
   logic [63:0]        sum_ff, sum_in;        // sum of squares
   logic [31:0]        mag_ff, mag_in;
   logic [30:0]        s_ff, s_in;            // drag scalar
   logic signed [63:0] t_ff, t_in;
   logic signed [31:0] adt_ff, adt_in;
   logic signed [31:0] half_ff, half_in;
   logic               neg_ff, neg_in;
   logic [15:0]        dt_ff, dt_in;
   logic signed [31:0] force_ff [3];
   logic signed [31:0] force_in [3];
   logic signed [31:0] vec_ff [4][3];         // acc, vel, ang accel, ang vel
   logic signed [31:0] vec_in [4][3];
   logic signed [31:0] pr_ff [2][3];          // position, rotation
   logic signed [31:0] pr_in [2][3];
   logic signed [31:0] out_ff [12];
   logic signed [31:0] out_in [12];
   logic               rsp_valid_ff, rsp_valid_in;

   // shared units
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   sqrt_req_type       sq_req;
   logic               sq_done;
   logic [31:0]        sq_root;
   div_req_type        dv_req;
   logic               dv_done;
   logic [31:0]        dv_quot;

   rbis_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   rbis_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sq_req),
      .done  (sq_done),
      .root  (sq_root)
   );

   rbis_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dv_req),
      .done  (dv_done),
      .quot  (dv_quot)
   );

   // single datapath read port on the vector file (the result step reads it directly)
   logic [1:0]         rd_v;
   logic signed [31:0] vec_rd;
   logic signed [31:0] pr_rd;
   logic signed [31:0] lim_cur;
   logic signed [31:0] grav_sel;

   always_comb begin
      unique case (state_ff)
         ST_A_M2:          rd_v = VS_VEL;
         ST_I_M1:          rd_v = grp_ff ? VS_ANG : VS_ACC;
         ST_I_M3, ST_I_U3: rd_v = grp_ff ? VS_W : VS_VEL;
         default:          rd_v = vs_ff;
      endcase
   end

   assign vec_rd   = vec_ff[rd_v][ax_ff];
   assign pr_rd    = pr_ff[grp_ff][ax_ff];
   assign grav_sel = grav_ff[ax_ff];

   always_comb begin
      unique case (vs_ff)
         VS_ACC: lim_cur = max_acc_ff;
         VS_VEL: lim_cur = max_vel_ff;
         VS_ANG: lim_cur = RBIS_MAX_ANG_ACCEL;
         VS_W:   lim_cur = RBIS_MAX_ANG_VEL;
      endcase
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MAG_MUL: begin
            mul_a = {vec_rd[31], vec_rd};
            mul_b = {vec_rd[31], vec_rd};
         end
         ST_C_M: begin
            mul_a = {vec_rd[31], vec_rd};
            mul_b = {lim_cur[31], lim_cur};
         end
         ST_D_M1: begin
            mul_a = {1'b0, mag_ff};
            mul_b = {2'b0, drag_ff};
         end
         ST_D_M2: begin
            mul_a = {2'b0, s_ff};
            mul_b = {17'b0, RBIS_DRAG_HALF_RHO};
         end
         ST_D_M3: begin
            mul_a = {2'b0, s_ff};
            mul_b = {2'b0, invm_ff};
         end
         ST_A_M1: begin
            mul_a = {force_ff[ax_ff][31], force_ff[ax_ff]};
            mul_b = {2'b0, invm_ff};
         end
         ST_A_M2: begin
            mul_a = {vec_rd[31], vec_rd};
            mul_b = {2'b0, s_ff};
         end
         ST_I_M1, ST_I_M3: begin
            mul_a = {vec_rd[31], vec_rd};
            mul_b = {17'b0, dt_ff};
         end
         ST_I_M2: begin
            mul_a = {adt_ff[31], adt_ff};
            mul_b = {17'b0, dt_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // product views (arithmetic shift is a floor)
   logic signed [65:0] p_shf;
   logic signed [65:0] p_sh16;
   logic signed [65:0] p_sh17;
   logic signed [65:0] p_abs;
   logic [63:0]        sum_nx;
   logic [30:0]        p_sat31;
   logic signed [65:0] acc_sum;
   logic signed [65:0] pos_sum;
   logic signed [65:0] vel_sum;
   logic               mag_over;

   assign p_shf   = mul_p >>> RBIS_FRAC_BITS;
   assign p_sh16  = mul_p >>> 16;
   assign p_sh17  = mul_p >>> 17;
   assign p_abs   = mul_p[65] ? -mul_p : mul_p;
   assign sum_nx  = sum_ff + mul_p[63:0];
   assign p_sat31 = (|p_shf[65:31]) ? 31'h7FFFFFFF : p_shf[30:0];
   assign acc_sum = {{2{t_ff[63]}}, t_ff} - p_shf;
   assign pos_sum = {{34{pr_rd[31]}}, pr_rd} + {{34{half_ff[31]}}, half_ff} + p_sh16;
   assign vel_sum = {{34{vec_rd[31]}}, vec_rd} + {{34{adt_ff[31]}}, adt_ff};
   assign mag_over = {1'b0, sq_root} > {2'b0, lim_cur[30:0]};

   always_comb begin
      state_in     = state_ff;
      ax_in        = ax_ff;
      vs_in        = vs_ff;
      grp_in       = grp_ff;
      drag_ph_in   = drag_ph_ff;
      sum_in       = sum_ff;
      mag_in       = mag_ff;
      s_in         = s_ff;
      t_in         = t_ff;
      adt_in       = adt_ff;
      half_in      = half_ff;
      neg_in       = neg_ff;
      dt_in        = dt_ff;
      force_in     = force_ff;
      vec_in       = vec_ff;
      pr_in        = pr_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;
      sq_req       = '0;
      dv_req       = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dt_in          = req_time_step;
               force_in[0]    = req_force_x;
               force_in[1]    = req_force_y;
               force_in[2]    = req_force_z;
               vec_in[VS_ANG][0] = req_ang_accel_x;
               vec_in[VS_ANG][1] = req_ang_accel_y;
               vec_in[VS_ANG][2] = req_ang_accel_z;
               if (mode_ff[0]) begin
                  // static body: state untouched, tick discarded
                  state_in = ST_FIN;
               end else begin
                  drag_ph_in = 1'b1;
                  vs_in      = VS_VEL;
                  ax_in      = 2'd0;
                  sum_in     = '0;
                  state_in   = ST_MAG_MUL;
               end
            end
         end
         ST_MAG_MUL: state_in = ST_MAG_ACC;
         ST_MAG_ACC: begin
            if (ax_ff == 2'd2) begin
               sq_req.start    = 1'b1;
               sq_req.radicand = sum_nx;
               state_in        = ST_MAG_SQRT;
            end else begin
               sum_in   = sum_nx;
               ax_in    = ax_ff + 2'd1;
               state_in = ST_MAG_MUL;
            end
         end
         ST_MAG_SQRT: begin
            if (sq_done) begin
               mag_in = sq_root;
               if (drag_ph_ff) begin
                  drag_ph_in = 1'b0;
                  state_in   = ST_D_M1;
               end else if (mag_over) begin
                  ax_in    = 2'd0;
                  state_in = ST_C_M;
               end else if (vs_ff == VS_W) begin
                  grp_in   = 1'b0;
                  ax_in    = 2'd0;
                  state_in = ST_I_M1;
               end else begin
                  vs_in    = vs_ff + 2'd1;
                  state_in = ST_C_SEL;
               end
            end
         end
         ST_D_M1: state_in = ST_D_U1;
         ST_D_U1: begin
            s_in     = p_sat31;
            state_in = ST_D_M2;
         end
         ST_D_M2: state_in = ST_D_U2;
         ST_D_U2: begin
            s_in     = mul_p[46:16];
            state_in = ST_D_M3;
         end
         ST_D_M3: state_in = ST_D_U3;
         ST_D_U3: begin
            s_in     = p_sat31;
            ax_in    = 2'd0;
            state_in = ST_A_M1;
         end
         ST_A_M1: state_in = ST_A_U1;
         ST_A_U1: begin
            t_in = p_shf[63:0];
            if (mode_ff[1]) begin
               t_in = p_shf[63:0] + {{32{grav_sel[31]}}, grav_sel};
            end
            state_in = ST_A_M2;
         end
         ST_A_M2: state_in = ST_A_U2;
         ST_A_U2: begin
            vec_in[VS_ACC][ax_ff] = sat32(acc_sum);
            if (ax_ff == 2'd2) begin
               vs_in    = VS_ACC;
               state_in = ST_C_SEL;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = ST_A_M1;
            end
         end
         ST_C_SEL: begin
            if (!lim_cur[31]) begin
               sum_in   = '0;
               ax_in    = 2'd0;
               state_in = ST_MAG_MUL;
            end else if (vs_ff == VS_W) begin
               grp_in   = 1'b0;
               ax_in    = 2'd0;
               state_in = ST_I_M1;
            end else begin
               vs_in = vs_ff + 2'd1;
            end
         end
         ST_C_M: state_in = ST_C_DIV;
         ST_C_DIV: begin
            dv_req.start    = 1'b1;
            dv_req.dividend = p_abs[63:0];
            dv_req.divisor  = mag_ff;
            neg_in          = mul_p[65];
            state_in        = ST_C_W;
         end
         ST_C_W: begin
            if (dv_done) begin
               vec_in[vs_ff][ax_ff] = neg_ff ? -dv_quot : dv_quot;
               if (ax_ff != 2'd2) begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = ST_C_M;
               end else if (vs_ff == VS_W) begin
                  grp_in   = 1'b0;
                  ax_in    = 2'd0;
                  state_in = ST_I_M1;
               end else begin
                  vs_in    = vs_ff + 2'd1;
                  state_in = ST_C_SEL;
               end
            end
         end
         ST_I_M1: state_in = ST_I_U1;
         ST_I_U1: begin
            adt_in   = p_sh16[31:0];
            state_in = ST_I_M2;
         end
         ST_I_M2: state_in = ST_I_U2;
         ST_I_U2: begin
            half_in  = p_sh17[31:0];
            state_in = ST_I_M3;
         end
         ST_I_M3: state_in = ST_I_U3;
         ST_I_U3: begin
            pr_in[grp_ff][ax_ff]  = sat32(pos_sum);
            vec_in[rd_v][ax_ff]   = sat32(vel_sum);
            if (ax_ff != 2'd2) begin
               ax_in    = ax_ff + 2'd1;
               state_in = ST_I_M1;
            end else if (!grp_ff) begin
               grp_in   = 1'b1;
               ax_in    = 2'd0;
               state_in = ST_I_M1;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               out_in[0]    = pr_ff[0][0];
               out_in[1]    = pr_ff[0][1];
               out_in[2]    = pr_ff[0][2];
               out_in[3]    = pr_ff[1][0];
               out_in[4]    = pr_ff[1][1];
               out_in[5]    = pr_ff[1][2];
               out_in[6]    = vec_ff[VS_VEL][0];
               out_in[7]    = vec_ff[VS_VEL][1];
               out_in[8]    = vec_ff[VS_VEL][2];
               out_in[9]    = vec_ff[VS_W][0];
               out_in[10]   = vec_ff[VS_W][1];
               out_in[11]   = vec_ff[VS_W][2];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ax_ff        <= '0;
         vs_ff        <= '0;
         grp_ff       <= 1'b0;
         drag_ph_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int v = 0; v < 4; v++) begin
            for (int a = 0; a < 3; a++) begin
               vec_ff[v][a] <= '0;
            end
         end
         for (int g = 0; g < 2; g++) begin
            for (int a = 0; a < 3; a++) begin
               pr_ff[g][a] <= '0;
            end
         end
      end else begin
         state_ff     <= state_in;
         ax_ff        <= ax_in;
         vs_ff        <= vs_in;
         grp_ff       <= grp_in;
         drag_ph_ff   <= drag_ph_in;
         rsp_valid_ff <= rsp_valid_in;
         vec_ff       <= vec_in;
         pr_ff        <= pr_in;
      end
      sum_ff   <= sum_in;
      mag_ff   <= mag_in;
      s_ff     <= s_in;
      t_ff     <= t_in;
      adt_ff   <= adt_in;
      half_ff  <= half_in;
      neg_ff   <= neg_in;
      dt_ff    <= dt_in;
      force_ff <= force_in;
      out_ff   <= out_in;
   end

   // ---------------- ports ----------------
   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_pos_x    = out_ff[0];
   assign rsp_out_pos_y    = out_ff[1];
   assign rsp_out_pos_z    = out_ff[2];
   assign rsp_out_pitch    = out_ff[3];
   assign rsp_out_yaw      = out_ff[4];
   assign rsp_out_roll     = out_ff[5];
   assign rsp_out_vel_x    = out_ff[6];
   assign rsp_out_vel_y    = out_ff[7];
   assign rsp_out_vel_z    = out_ff[8];
   assign rsp_out_angvel_x = out_ff[9];
   assign rsp_out_angvel_y = out_ff[10];
   assign rsp_out_angvel_z = out_ff[11];

   // ---------------- assertions ----------------
   `RBIS_ASSERT_NXT(a_accept_busy, clock, reset, req_valid && req_ready, state_ff != ST_IDLE, "sequencer did not leave idle after an accepted beat")
   `RBIS_ASSERT_IMP(a_sqrt_owner, clock, reset, sq_done, state_ff == ST_MAG_SQRT, "root finished while no magnitude step waits")
   `RBIS_ASSERT_IMP(a_div_owner, clock, reset, dv_done, state_ff == ST_C_W, "divider finished while no clamp step waits")
   `RBIS_ASSERT_NXT(a_fin_hold, clock, reset, state_ff == ST_FIN && rsp_valid && !rsp_ready, state_ff == ST_FIN, "result step left while the output register was full")

endmodule

[design/rbis_mul.sv]
// Shared registered 33x33 signed multiplier.
// No package dependencies.
module rbis_mul (
   input  logic               clock,
   input  logic signed [32:0] mul_a,
   input  logic signed [32:0] mul_b,
   output logic signed [65:0] mul_p
);

   logic signed [65:0] prod_ff;
   logic signed [65:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

[design/rbis_sqrt.sv]
// Bit-serial integer square root, 64-bit radicand, one root bit per cycle.
// Depends on rbis_pkg.
module rbis_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  rbis_pkg::sqrt_req_type req,
   output logic                  done,
   output logic [31:0]           root
);
   import rbis_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] rad_ff, rad_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [35:0] rem_sh;
   logic [35:0] trial;

   assign rem_sh = {rem_ff, rad_ff[63:62]};
   assign trial  = {2'b00, root_ff, 2'b01};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = req.radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         if (rem_sh >= trial) begin
            rem_in  = 34'(rem_sh - trial);
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh[33:0];
            root_in = {root_ff[30:0], 1'b0};
         end
         rad_in = {rad_ff[61:0], 2'b00};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[design/rbis_div.sv]
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// Requires dividend < divisor * 2^32. Depends on rbis_pkg.
module rbis_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rbis_pkg::div_req_type req,
   output logic                 done,
   output logic [31:0]          quot
);
   import rbis_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] num_ff, num_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [31:0] q_ff, q_in;
   logic [32:0] rem_sh;

   assign rem_sh = {rem_ff, num_ff[31]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = req.dividend[63:32];
         num_in  = req.dividend[31:0];
         den_in  = req.divisor;
         q_in    = '0;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = 32'(rem_sh - {1'b0, den_ff});
            q_in   = {q_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            q_in   = {q_ff[30:0], 1'b0};
         end
         num_in = {num_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

[sim/tb_rigid_body_integration_step_core.sv]
// Self-checking bench for the rigid body integration step core: random and directed ticks.
// Depends on rbis_pkg and rigid_body_integration_step_core; predicts every result beat.
module tb_rigid_body_integration_step_core;
   timeunit 1ns;
   timeprecision 1ps;
   import rbis_pkg::*;

   localparam int FRAC = 16;
   localparam longint S32MAX = 64'sd2147483647;
   localparam longint S32MIN = -64'sd2147483648;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 800;

   typedef struct packed {
      logic [15:0]        dt;
      logic signed [31:0] fx, fy, fz, ax, ay, az;
   } tick_type;

   typedef struct packed {
      logic signed [31:0] px, py, pz, pitch, yaw, roll, vx, vy, vz, wx, wy, wz;
   } body_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [15:0] req_time_step = '0;
   logic signed [31:0] req_force_x = '0, req_force_y = '0, req_force_z = '0;
   logic signed [31:0] req_ang_accel_x = '0, req_ang_accel_y = '0, req_ang_accel_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_out_pos_x, rsp_out_pos_y, rsp_out_pos_z;
   logic signed [31:0] rsp_out_pitch, rsp_out_yaw, rsp_out_roll;
   logic signed [31:0] rsp_out_vel_x, rsp_out_vel_y, rsp_out_vel_z;
   logic signed [31:0] rsp_out_angvel_x, rsp_out_angvel_y, rsp_out_angvel_z;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   always #6 clock = ~clock;

   rigid_body_integration_step_core DUT (.*);

   // model copy of registers and body state
   logic [1:0]         m_mode;
   logic [30:0]        m_inv_mass, m_drag;
   logic signed [31:0] m_grav [3];
   logic signed [31:0] m_max_acc, m_max_vel;
   longint             m_pos [3], m_rot [3], m_vel [3], m_angv [3];

   tick_type       tick_queue [$];
   body_state_type expected_states [$];
   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  no_idle = 1'b0;
   int  send_gap = 0, recv_gap = 0;
   int  hold_until_drained = 0;
   tick_type held_tick;
   bit    req_ready_seen = 1'b0;

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;  // arithmetic shift is a floor
   endfunction

   function automatic longint sat32(longint v);
      if (v > S32MAX) return S32MAX;
      if (v < S32MIN) return S32MIN;
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res = 0, b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned vec_magnitude(longint v0, longint v1, longint v2);
      longint unsigned a0 = v0 < 0 ? -v0 : v0;
      longint unsigned a1 = v1 < 0 ? -v1 : v1;
      longint unsigned a2 = v2 < 0 ? -v2 : v2;
      return int_sqrt(a0 * a0 + a1 * a1 + a2 * a2);
   endfunction

   // scale vector to lim when its magnitude exceeds it (truncating divide)
   task automatic limit_vec(ref longint v [3], input longint lim);
      longint unsigned m;
      if (lim < 0) return;
      m = vec_magnitude(v[0], v[1], v[2]);
      if (m > longint'(lim))
         for (int i = 0; i < 3; i++) v[i] = (v[i] * lim) / longint'(m);
   endtask

   task automatic integrate_axis(ref longint p, ref longint v, input longint a,
                                 input longint dt);
      longint adt, half, vdt;
      adt  = floor_shr(a * dt, 16);
      half = floor_shr(adt * dt, 17);
      vdt  = floor_shr(v * dt, 16);
      p = sat32(p + half + vdt);
      v = sat32(v + adt);
   endtask

   function automatic body_state_type pack_state();
      body_state_type s;
      s = {32'(m_pos[0]), 32'(m_pos[1]), 32'(m_pos[2]),
           32'(m_rot[0]), 32'(m_rot[1]), 32'(m_rot[2]),
           32'(m_vel[0]), 32'(m_vel[1]), 32'(m_vel[2]),
           32'(m_angv[0]), 32'(m_angv[1]), 32'(m_angv[2])};
      return s;
   endfunction

   // advance the model body by one tick and queue the expected state
   task automatic predict_tick(tick_type t);
      longint acc [3], ang [3], vel [3], w [3], f [3];
      longint unsigned vm, s;
      longint dt, sum;
      if (!m_mode[0]) begin
         dt = longint'(t.dt);
         f[0] = t.fx; f[1] = t.fy; f[2] = t.fz;
         ang[0] = t.ax; ang[1] = t.ay; ang[2] = t.az;
         for (int i = 0; i < 3; i++) begin
            vel[i] = m_vel[i];
            w[i] = m_angv[i];
         end
         vm = vec_magnitude(vel[0], vel[1], vel[2]);
         s = (vm * longint'(m_drag)) >> FRAC;
         if (s > S32MAX) s = S32MAX;
         s = (s * longint'(RBIS_DRAG_HALF_RHO)) >> 16;
         s = (s * longint'(m_inv_mass)) >> FRAC;
         if (s > S32MAX) s = S32MAX;
         for (int i = 0; i < 3; i++) begin
            sum = floor_shr(f[i] * longint'(m_inv_mass), FRAC);
            if (m_mode[1]) sum += m_grav[i];
            sum -= floor_shr(vel[i] * longint'(s), FRAC);
            acc[i] = sat32(sum);
         end
         limit_vec(acc, m_max_acc);
         limit_vec(vel, m_max_vel);
         limit_vec(ang, RBIS_MAX_ANG_ACCEL);
         limit_vec(w, RBIS_MAX_ANG_VEL);
         for (int i = 0; i < 3; i++) begin
            m_vel[i] = vel[i];
            m_angv[i] = w[i];
            integrate_axis(m_pos[i], m_vel[i], acc[i], dt);
            integrate_axis(m_rot[i], m_angv[i], ang[i], dt);
         end
      end
      expected_states.push_back(pack_state());
   endtask

   // ---------------------------------------------------------------------
   // Driver: falling-edge updates, beat handed over at the rising edge.
   // Prediction happens when the beat is actually taken.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready_seen) begin
            predict_tick(held_tick);
         end
         if (req_valid && !req_ready_seen) begin
            // beat still pending, payload held
         end else if (hold_until_drained > 0 && expected_states.size() != 0) begin
            req_valid <= 1'b0;
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (tick_queue.size() != 0) begin
            if (hold_until_drained > 0) hold_until_drained = 0;
            held_tick = tick_queue.pop_front();
            req_valid <= 1'b1;
            {req_time_step, req_force_x, req_force_y, req_force_z,
             req_ang_accel_x, req_ang_accel_y, req_ang_accel_z} <= held_tick;
            if (!no_idle && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 8);
         end else begin
            req_valid <= 1'b0;
         end
         // receiver stall bursts
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 4) == 0) begin
            recv_gap = $urandom_range(0, 7);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: samples the handshakes at the rising edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      body_state_type got, want;
      req_ready_seen <= req_valid && req_ready && !reset;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_out_pos_x, rsp_out_pos_y, rsp_out_pos_z,
                rsp_out_pitch, rsp_out_yaw, rsp_out_roll,
                rsp_out_vel_x, rsp_out_vel_y, rsp_out_vel_z,
                rsp_out_angvel_x, rsp_out_angvel_y, rsp_out_angvel_z};
         if (expected_states.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result beat: %h", got);
         end else begin
            want = expected_states.pop_front();
            for (int i = 0; i < 12; i++) begin
               if (got[i*32 +: 32] !== want[i*32 +: 32]) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Mismatch field %0d: expected %0d actual %0d", 11 - i,
                              $signed(want[i*32 +: 32]), $signed(got[i*32 +: 32]));
               end
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // APB write: setup then access, register taken at the access edge
   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_MODE_FLAGS:   m_mode = value[1:0];
         REG_INVERSE_MASS: m_inv_mass = value[30:0];
         REG_GRAVITY_X:    m_grav[0] = value;
         REG_GRAVITY_Y:    m_grav[1] = value;
         REG_GRAVITY_Z:    m_grav[2] = value;
         REG_DRAG_COEFF:   m_drag = value[30:0];
         REG_MAX_LIN_ACC:  m_max_acc = value;
         default:          m_max_vel = value;
      endcase
   endtask

   // wait for the block to drain before reconfiguring
   task automatic drain();
      while (tick_queue.size() != 0 || req_valid || expected_states.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_field();
      case ($urandom_range(0, 5))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return $urandom();
         default: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sd131072;
      endcase
   endfunction

   function automatic tick_type rand_tick();
      tick_type t;
      t.dt = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2000));
      t.fx = rand_field(); t.fy = rand_field(); t.fz = rand_field();
      t.ax = rand_field(); t.ay = rand_field(); t.az = rand_field();
      return t;
   endfunction

   function automatic logic [31:0] rand_limit();
      case ($urandom_range(0, 3))
         0: return 32'hFFFF0000;
         1: return 32'h7FFFFFFF;
         2: return 32'd0;
         default: return $urandom_range(1, 32'h00400000);
      endcase
   endfunction

   initial begin
      tick_type t;
      m_mode = RST_MODE_FLAGS; m_inv_mass = RST_INVERSE_MASS;
      m_grav[0] = 0; m_grav[1] = RST_GRAVITY_Y; m_grav[2] = 0;
      m_drag = '0; m_max_acc = RST_LIMIT; m_max_vel = RST_LIMIT;
      for (int i = 0; i < 3; i++) begin
         m_pos[i] = 0; m_rot[i] = 0; m_vel[i] = 0; m_angv[i] = 0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: reset defaults, zero and full dt, field extremes, one small mixed tick
      tick_queue.push_back('{16'd0, 0, 0, 0, 0, 0, 0});
      tick_queue.push_back('{16'hFFFF, 0, 0, 0, 0, 0, 0});
      tick_queue.push_back('{16'hFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                             32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF});
      tick_queue.push_back('{16'hFFFF, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                             32'sh80000000, 32'sh80000000, 32'sh80000000});
      tick_queue.push_back('{16'h8000, 32'sh00010000, -32'sh00010000, 0, 1, -1, 0});
      drain();
      // drag on, limits on, extreme inverse mass and gravity
      csr_write(REG_DRAG_COEFF, 32'h7FFFFFFF);
      csr_write(REG_MAX_LIN_ACC, 32'h00020000);
      csr_write(REG_MAX_LIN_VEL, 32'h00030000);
      csr_write(REG_INVERSE_MASS, 32'h7FFFFFFF);
      csr_write(REG_GRAVITY_X, 32'h80000000);
      csr_write(REG_GRAVITY_Z, 32'h7FFFFFFF);
      csr_write(REG_GRAVITY_Y, 32'h00000000);
      for (int i = 0; i < 6; i++) tick_queue.push_back(rand_tick());
      drain();
      // static body: force is discarded
      csr_write(REG_MODE_FLAGS, 32'd3);
      for (int i = 0; i < 4; i++) tick_queue.push_back(rand_tick());
      drain();
      csr_write(REG_MODE_FLAGS, 32'd0);
      csr_write(REG_MAX_LIN_ACC, 32'd0);
      csr_write(REG_MAX_LIN_VEL, 32'd0);
      for (int i = 0; i < 4; i++) tick_queue.push_back(rand_tick());
      drain();

      // random phases with varying settings
      for (int ph = 0; ph < 16; ph++) begin
         csr_write(REG_MODE_FLAGS, $urandom_range(0, 7) == 0 ? 32'd1 : $urandom_range(0, 3) & 2);
         csr_write(REG_INVERSE_MASS, ph == 0 ? 32'd0 :
                   ($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h40000)));
         csr_write(REG_GRAVITY_X, rand_field());
         csr_write(REG_GRAVITY_Y, rand_field());
         csr_write(REG_GRAVITY_Z, rand_field());
         csr_write(REG_DRAG_COEFF, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h20000));
         csr_write(REG_MAX_LIN_ACC, rand_limit());
         csr_write(REG_MAX_LIN_VEL, rand_limit());
         if (ph == 15) no_idle = 1'b1;
         for (int i = 0; i < 95; i++) begin
            t = rand_tick();
            tick_queue.push_back(t);
         end
         if (ph == 4) begin
            // pause the sender mid-phase while a result is still owed
            while (tick_queue.size() > 60 || expected_states.size() == 0)
               @(posedge clock);
            hold_until_drained = 1;
         end
         drain();
      end
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/rbis_pkg.sv
design/rbis_mul.sv
design/rbis_sqrt.sv
design/rbis_div.sv
design/rigid_body_integration_step_core.sv
sim/tb_rigid_body_integration_step_core.sv
